[hw/rtl/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge once reset is released
`define ASSERT_CLKD(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/xrr_pkg.sv]
package xrr_pkg;

   localparam int WINDOW_MAX = 16;
   localparam int LEN_W      = $clog2(WINDOW_MAX + 1);
   localparam int OFFSET_W   = 48;
   localparam int HINT_BYTES = 16;
   localparam int CSR_IDX_W  = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_XOR_KEY      = 3'd0,
      CSR_ROTATE       = 3'd1,
      CSR_PATTERN_LEN  = 3'd2,
      CSR_PATTERN_LOW  = 3'd3,
      CSR_PATTERN_HIGH = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [7:0] enc_count;
      logic [7:0] enc_symbol;
   } req_type;

   typedef struct packed {
      logic [7:0]          run_symbol;
      logic [7:0]          run_length;
      logic                match_now;
      logic [OFFSET_W-1:0] match_offset;
      logic                found;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  xor_key;
      logic [2:0]  rotate_amount;
      logic [4:0]  pattern_length;
      logic [63:0] pattern_low;
      logic [63:0] pattern_high;
   } cfg_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic post;
   } cmd_type;

   typedef struct packed {
      logic run_left;
   } status_type;

   // xor with the key, then rotate right
   function automatic logic [7:0] decrypt_byte(logic [7:0] b, logic [7:0] key,
                                               logic [2:0] rot);
      logic [15:0] dbl;
      dbl = {b ^ key, b ^ key} >> rot;
      return dbl[7:0];
   endfunction

endpackage

[hw/rtl/xrr_csr.sv]
module xrr_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [xrr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [63:0]                      csr_data,
   output xrr_pkg::cfg_type                 cfg
);

   xrr_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            xrr_pkg::CSR_XOR_KEY:      cfg_in.xor_key        = csr_data[7:0];
            xrr_pkg::CSR_ROTATE:       cfg_in.rotate_amount  = csr_data[2:0];
            xrr_pkg::CSR_PATTERN_LEN:  cfg_in.pattern_length = csr_data[4:0];
            xrr_pkg::CSR_PATTERN_LOW:  cfg_in.pattern_low    = csr_data;
            xrr_pkg::CSR_PATTERN_HIGH: cfg_in.pattern_high   = csr_data;
            default: ;  // unmapped index, dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.xor_key        <= 8'd0;
         cfg_ff.rotate_amount  <= 3'd1;
         cfg_ff.pattern_length <= 5'd1;
         cfg_ff.pattern_low    <= 64'd0;
         cfg_ff.pattern_high   <= 64'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hw/rtl/xrr_ctrl.sv]
`include "assert_macros.svh"

module xrr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  xrr_pkg::status_type  status,
   output xrr_pkg::cmd_type     cmd
);

   xrr_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         xrr_pkg::ST_IDLE: if (req_valid) state_in = xrr_pkg::ST_RUN;
         xrr_pkg::ST_RUN:  if (!status.run_left && slot_free) state_in = xrr_pkg::ST_IDLE;
         default:          state_in = xrr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == xrr_pkg::ST_IDLE);
      cmd.load  = req_ready && req_valid;
      cmd.step  = (state_ff == xrr_pkg::ST_RUN) && status.run_left;
      cmd.post  = (state_ff == xrr_pkg::ST_RUN) && !status.run_left && slot_free;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.post)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= xrr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ASSERT_CLKD(a_post_slot_free, clock, reset, cmd.post |-> (!rsp_valid_ff || rsp_ready), "result posted over an untaken beat")
   `ASSERT_CLKD(a_load_enters_run, clock, reset, cmd.load |=> (state_ff == xrr_pkg::ST_RUN), "accepted beat did not start a run")
   `ASSERT_ALWAYS(a_cmd_exclusive, clock, reset || $onehot0({cmd.load, cmd.step, cmd.post}), "overlapping datapath commands")

endmodule

[hw/rtl/xrr_dp.sv]
`include "assert_macros.svh"

module xrr_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  xrr_pkg::cfg_type     cfg,
   input  xrr_pkg::req_type     req_data,
   input  xrr_pkg::cmd_type     cmd,
   output xrr_pkg::status_type  status,
   output xrr_pkg::rsp_type     rsp_data
);

   localparam int WM = xrr_pkg::WINDOW_MAX;
   localparam int LW = xrr_pkg::LEN_W;
   localparam int OW = xrr_pkg::OFFSET_W;

   logic [7:0]    window_ff [WM];
   logic [7:0]    window_in [WM];
   logic [7:0]    hint_ff   [WM];
   logic [7:0]    hint_in   [WM];
   logic [WM-1:0] mask_ff, mask_in;
   logic [LW-1:0] len_ff, len_in;
   logic [7:0]    symbol_ff, count_ff, left_ff;
   logic [7:0]    dec_count, dec_symbol;
   logic [LW-1:0] fill_ff, fill_in;
   logic [OW-1:0] offset_ff, found_off_ff;
   logic          found_ff, match_now_ff, hit;
   logic [8*xrr_pkg::HINT_BYTES-1:0] hint_vec;
   xrr_pkg::rsp_type rsp_ff;

   assign dec_count  = xrr_pkg::decrypt_byte(req_data.enc_count, cfg.xor_key,
                                             cfg.rotate_amount);
   assign dec_symbol = xrr_pkg::decrypt_byte(req_data.enc_symbol, cfg.xor_key,
                                             cfg.rotate_amount);
   assign hint_vec   = {cfg.pattern_high, cfg.pattern_low};

   // clamp length to 1..window size
   always_comb begin
      if (cfg.pattern_length == 5'd0)
         len_in = LW'(1);
      else if (int'(cfg.pattern_length) > WM)
         len_in = LW'(WM);
      else
         len_in = LW'(cfg.pattern_length);
   end

   // hint bytes lined up with the window, newest symbol at slot 0
   always_comb begin
      int idx;
      for (int p = 0; p < WM; p++) begin
         idx        = int'(len_in) - 1 - p;
         mask_in[p] = (p < int'(len_in));
         if (mask_in[p] && idx < xrr_pkg::HINT_BYTES)
            hint_in[p] = hint_vec[8*idx +: 8];
         else
            hint_in[p] = 8'd0;
      end
   end

   always_comb begin
      window_in[0] = symbol_ff;
      for (int p = 1; p < WM; p++) window_in[p] = window_ff[p-1];
   end

   assign fill_in = (int'(fill_ff) < WM) ? fill_ff + LW'(1) : fill_ff;

   always_comb begin
      hit = (fill_in >= len_ff);
      for (int p = 0; p < WM; p++)
         if (mask_ff[p] && window_in[p] != hint_ff[p]) hit = 1'b0;
   end

   assign status.run_left = (left_ff != 8'd0);
   assign rsp_data        = rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         for (int p = 0; p < WM; p++) window_ff[p] <= window_in[p];
      end
      if (cmd.load) begin
         for (int p = 0; p < WM; p++) hint_ff[p] <= hint_in[p];
         mask_ff   <= mask_in;
         len_ff    <= len_in;
         symbol_ff <= dec_symbol;
         count_ff  <= dec_count;
      end
      if (cmd.post) begin
         rsp_ff.run_symbol   <= symbol_ff;
         rsp_ff.run_length   <= count_ff;
         rsp_ff.match_now    <= match_now_ff;
         rsp_ff.match_offset <= found_off_ff;
         rsp_ff.found        <= found_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= 8'd0;
         fill_ff      <= '0;
         offset_ff    <= '0;
         found_ff     <= 1'b0;
         found_off_ff <= '0;
         match_now_ff <= 1'b0;
      end else if (cmd.load) begin
         left_ff      <= dec_count;
         match_now_ff <= 1'b0;
      end else if (cmd.step) begin
         left_ff   <= left_ff - 8'd1;
         fill_ff   <= fill_in;
         offset_ff <= offset_ff + OW'(1);
         if (!found_ff && hit) begin
            found_ff     <= 1'b1;
            found_off_ff <= offset_ff + OW'(1) - OW'(len_ff);
            match_now_ff <= 1'b1;
         end
      end
   end

   `ASSERT_CLKD(a_found_sticky, clock, reset, $past(found_ff) |-> found_ff, "found flag dropped")

endmodule

[hw/rtl/xor_rotate_rle_match_top.sv]
// xor/rotate decrypt, rle expand and pattern search
// req channel: one beat per encrypted run, enc_count and enc_symbol; both bytes
//   are xored with the key and rotated right before use
// csr channel: writes of xor key, rotation, pattern length, hint bytes; always
//   ready; user writes only while the block is idle, unchecked; others dropped
// rsp channel: one beat per run with decrypted symbol and length, match_now when
//   the first hint match fell inside this run, the start offset of that match
//   and the sticky found flag
// timing: a run of n symbols expands one symbol per cycle through the window
//   shift line; its result is posted after the last symbol, once the output
//   register is free, and the next req beat is taken only after that post
// the result sits in an output register; while it waits the next run is
//   accepted and expanded, and only the post of that run stalls on rsp_ready
// reset (synchronous, active high) restores register defaults, clears the
//   offset, fill and found state; window contents are not cleared
module xor_rotate_rle_match_top (
   input  logic                          clock,
   input  logic                          reset,
   // input runs
   input  logic                          req_valid,
   output logic                          req_ready,
   input  xrr_pkg::req_type              req_data,
   // results
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output xrr_pkg::rsp_type              rsp_data,
   // register writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [xrr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]                   csr_data
);

   xrr_pkg::cfg_type    cfg;
   xrr_pkg::cmd_type    cmd;
   xrr_pkg::status_type status;

   // configuration registers
   xrr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // sequencer: accept, expand, post
   xrr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // decrypt, window, compare and offsets
   xrr_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

[tb/xor_rotate_rle_match_top_tb.sv]
`timescale 1ns / 100ps

module xor_rotate_rle_match_top_tb;
   import xrr_pkg::*;

   // receiver hold long enough to back the block up into its input
   localparam int unsigned LONG_HOLD   = 400;
   // quiet cycles before the run is declared hung: longest run plus the long
   // hold plus sender gaps, several times over
   localparam int unsigned STALL_LIMIT = 4000;
   // drain time after the last result, longer than one full run
   localparam int unsigned TAIL_CYCLES = 300;
   localparam int unsigned RAND_PHASES = 10;
   localparam int unsigned PHASE_RUNS  = 105;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_MAPPED = CSR_PATTERN_HIGH;

   typedef enum int {
      DRAIN_FREE,
      DRAIN_COIN,
      DRAIN_SPARSE,
      DRAIN_LIGHT
   } drain_mode_type;

   // scoreboard: own copy of registers and search state, expected results in order
   class match_scoreboard;
      logic [7:0]          xor_key;
      logic [2:0]          rot;
      logic [4:0]          pat_len;
      logic [63:0]         hint_lo;
      logic [63:0]         hint_hi;
      logic [7:0]          window [WINDOW_MAX];
      int unsigned         head;
      int unsigned         held;
      logic [OFFSET_W-1:0] stream_pos;
      logic [OFFSET_W-1:0] hit_start;
      bit                  found;
      rsp_type             expected_runs [$];
      int unsigned         mismatches;
      int unsigned         runs_in;
      int unsigned         runs_out;
      int unsigned         reg_writes;

      function new();
         xor_key    = 8'h00;
         rot        = 3'd1;
         pat_len    = 5'd1;
         hint_lo    = '0;
         hint_hi    = '0;
         head       = 0;
         held       = 0;
         stream_pos = '0;
         hit_start  = '0;
         found      = 1'b0;
         mismatches = 0;
         runs_in    = 0;
         runs_out   = 0;
         reg_writes = 0;
         foreach (window[i]) window[i] = 8'h00;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [63:0] d);
         reg_writes++;
         case (idx)
            CSR_XOR_KEY:      xor_key = d[7:0];
            CSR_ROTATE:       rot     = d[2:0];
            CSR_PATTERN_LEN:  pat_len = d[4:0];
            CSR_PATTERN_LOW:  hint_lo = d;
            CSR_PATTERN_HIGH: hint_hi = d;
            default: ;
         endcase
      endfunction

      function logic [7:0] decrypt(logic [7:0] b);
         logic [7:0] v;
         v = b ^ xor_key;
         if (rot == 3'd0) return v;
         return (v >> rot) | (v << (8 - rot));
      endfunction

      // inverse of decrypt, used to build plaintext runs
      function logic [7:0] encrypt(logic [7:0] p);
         logic [7:0] v;
         v = p;
         if (rot != 3'd0) v = (p << rot) | (p >> (8 - rot));
         return v ^ xor_key;
      endfunction

      function logic [7:0] hint_at(int unsigned k);
         if (k < 8) return hint_lo[8*k +: 8];
         if (k < 16) return hint_hi[8*(k-8) +: 8];
         return 8'h00;
      endfunction

      function int unsigned active_len();
         int unsigned l;
         l = pat_len;
         if (l == 0) l = 1;
         if (l > WINDOW_MAX) l = WINDOW_MAX;
         return l;
      endfunction

      function bit window_hit(int unsigned len);
         int unsigned start;
         start = (head + WINDOW_MAX - len) % WINDOW_MAX;
         for (int unsigned k = 0; k < len; k++)
            if (window[(start + k) % WINDOW_MAX] != hint_at(k)) return 1'b0;
         return 1'b1;
      endfunction

      // expand one accepted run and queue its result
      function void accept_run(req_type r);
         rsp_type     e;
         logic [7:0]  n;
         logic [7:0]  s;
         int unsigned len;
         n   = decrypt(r.enc_count);
         s   = decrypt(r.enc_symbol);
         len = active_len();
         e   = '0;
         for (int unsigned j = 0; j < n; j++) begin
            window[head] = s;
            head = (head + 1) % WINDOW_MAX;
            if (held < WINDOW_MAX) held++;
            if (!found && held >= len && window_hit(len)) begin
               found       = 1'b1;
               hit_start   = stream_pos + 1 - len;
               e.match_now = 1'b1;
            end
            stream_pos = stream_pos + 1;
         end
         e.run_symbol   = s;
         e.run_length   = n;
         e.match_offset = found ? hit_start : '0;
         e.found        = found;
         expected_runs.push_back(e);
         runs_in++;
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= 100) $display("[%0t] mismatch: %s", $time, msg);
      endtask

      task compare_field(string name, logic [63:0] got, logic [63:0] want);
         if (got !== want)
            report($sformatf("result %0d %s got %h want %h", runs_out, name, got, want));
      endtask

      task check_run(rsp_type got);
         rsp_type e;
         if (expected_runs.size() == 0) begin
            report($sformatf("result with no run pending: %p", got));
            return;
         end
         e = expected_runs.pop_front();
         runs_out++;
         compare_field("run_symbol", got.run_symbol, e.run_symbol);
         compare_field("run_length", got.run_length, e.run_length);
         compare_field("match_now", got.match_now, e.match_now);
         compare_field("match_offset", got.match_offset, e.match_offset);
         compare_field("found", got.found, e.found);
      endtask
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [63:0]          csr_data;

   match_scoreboard sb = new();

   int unsigned burst_left   = 0;
   int unsigned sent_runs    = 0;
   int unsigned long_holds   = 0;
   int unsigned quiet_cycles = 0;
   bit          hold_pending = 1'b0;

   xor_rotate_rle_match_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // input side
   // ---------------------------------------------------------------------------

   // one req beat; the sender works in bursts, mostly with idle gaps between them
   // valid is left high after the beat so a following beat keeps it asserted
   task automatic send_beat(req_type b);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         // about a third of the bursts follow on with no gap at all
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // beat taken at this edge, predict it with the settings in force now
      sb.accept_run(b);
      sent_runs++;
   endtask

   // plaintext run, encrypted with the current key and rotation
   task automatic send_plain(logic [7:0] count, logic [7:0] symbol);
      req_type b;
      b.enc_count  = sb.encrypt(count);
      b.enc_symbol = sb.encrypt(symbol);
      send_beat(b);
   endtask

   task automatic send_raw(logic [7:0] enc_count, logic [7:0] enc_symbol);
      req_type b;
      b.enc_count  = enc_count;
      b.enc_symbol = enc_symbol;
      send_beat(b);
   endtask

   // noise: mostly short runs of random symbols, sometimes fully random bytes
   task automatic send_noise();
      if ($urandom_range(0, 4) == 0)
         send_raw(8'($urandom), 8'($urandom));
      else
         send_plain(8'($urandom_range(0, 12)), 8'($urandom));
   endtask

   // hint pattern as a run sequence; runs are split at random and empty runs
   // slipped in, so the window straddles beats; with spoil one symbol is wrong
   task automatic send_pattern(bit spoil, int unsigned lead, int unsigned tail);
      logic [7:0]  seq [WINDOW_MAX];
      int unsigned n;
      int unsigned i;
      int unsigned j;
      int unsigned cnt;
      int unsigned piece;
      n = sb.active_len();
      for (int unsigned k = 0; k < n; k++) seq[k] = sb.hint_at(k);
      if (spoil) seq[$urandom_range(0, n - 1)] ^= 8'($urandom_range(1, 255));
      i = 0;
      while (i < n) begin
         j = i;
         while (j + 1 < n && seq[j + 1] == seq[i]) j++;
         cnt = j - i + 1;
         if (i == 0) cnt += lead;
         if (j == n - 1) cnt += tail;
         while (cnt != 0) begin
            piece = (cnt > 1 && $urandom_range(0, 3) == 0) ? $urandom_range(1, cnt - 1) : cnt;
            send_plain(8'(piece), seq[i]);
            cnt -= piece;
            // empty run: result only, window untouched
            if ($urandom_range(0, 9) == 0) send_plain(8'h00, 8'($urandom));
         end
         i = j + 1;
      end
   endtask

   // ---------------------------------------------------------------------------
   // register side
   // ---------------------------------------------------------------------------

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [63:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, d);
   endtask

   // block idle: no req beat offered and every result back
   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.expected_runs.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // all five registers plus one unmapped index; random upper bits on the
   // narrow registers check that only the low bits land
   task automatic load_settings(logic [7:0] key, logic [2:0] rot, logic [4:0] len,
                                logic [63:0] lo, logic [63:0] hi);
      logic [63:0] junk;
      junk = {$urandom, $urandom};
      wait_idle();
      write_reg(CSR_XOR_KEY, {junk[63:8], key});
      write_reg(CSR_ROTATE, {junk[63:3], rot});
      write_reg(CSR_PATTERN_LEN, {junk[63:5], len});
      write_reg(CSR_PATTERN_LOW, lo);
      write_reg(CSR_PATTERN_HIGH, hi);
      write_reg(CSR_LAST_MAPPED + CSR_IDX_W'($urandom_range(1, 3)), {$urandom, $urandom});
      csr_valid <= 1'b0;
   endtask

   // hint bytes with some repeats, so patterns come out as runs
   function automatic void make_hint(output logic [63:0] lo, output logic [63:0] hi);
      logic [127:0] h;
      h[7:0] = 8'($urandom);
      for (int k = 1; k < 16; k++)
         h[8*k +: 8] = ($urandom_range(0, 3) == 0) ? h[8*(k-1) +: 8] : 8'($urandom);
      lo = h[63:0];
      hi = h[127:64];
   endfunction

   // ---------------------------------------------------------------------------
   // result side: check each beat, stall on a pattern of its own
   // ---------------------------------------------------------------------------

   initial begin
      int unsigned    hold_left;
      int unsigned    mode_left;
      drain_mode_type mode;
      logic           next_ready;
      rsp_ready = 1'b0;
      hold_left = 0;
      mode_left = 0;
      mode      = DRAIN_FREE;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) sb.check_run(rsp_data);
         if (mode_left == 0) begin
            mode      = drain_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 128);
         end
         mode_left--;
         if (hold_left != 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else if (hold_pending) begin
            // long hold while the sender keeps offering beats
            hold_pending = 1'b0;
            hold_left    = LONG_HOLD - 1;
            long_holds++;
            next_ready   = 1'b0;
         end else begin
            case (mode)
               DRAIN_FREE:   next_ready = 1'b1;
               DRAIN_COIN:   next_ready = 1'($urandom_range(0, 1));
               DRAIN_SPARSE: next_ready = ($urandom_range(0, 3) == 0);
               default:      next_ready = ($urandom_range(0, 7) != 0);
            endcase
         end
         rsp_ready <= next_ready;
      end
   end

   // hang detection: cycles with no beat on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == STALL_LIMIT) begin
            $display("[%0t] no beat for %0d cycles", $time, STALL_LIMIT);
            $display("xor_rotate_rle_match_top regression: fail");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------

   initial begin
      logic [63:0] lo;
      logic [63:0] hi;
      logic [4:0]  len;
      int unsigned phase_end;
      int unsigned tries;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = CSR_XOR_KEY;
      csr_data  = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings (no key, rotate by one, one zero hint byte): zero and
      // full run lengths, symbols kept nonzero so nothing matches yet
      send_raw(8'h00, 8'h01);
      send_raw(8'hFF, 8'h80);
      send_raw(8'h01, 8'hFF);
      send_raw(8'h02, 8'h7F);
      send_raw(8'hFE, 8'h55);

      // all-ones key, widest rotation, pattern length zero acting as one;
      // no symbol equals the hint byte, so a zero-length search would show up
      load_settings(8'hFF, 3'd7, 5'd0, 64'h0123_4567_89AB_CD5A, 64'hFFFF_FFFF_FFFF_FFFF);
      send_raw(8'h00, 8'h00);
      send_raw(8'hFF, 8'hFF);
      send_raw(8'h00, 8'hFF);
      send_raw(8'hFF, 8'h00);
      send_plain(8'd3, 8'h5B);

      // clear key, no rotation, length above the window saturating to 16;
      // the hint is 5 x aa, 5 x bb, 6 x cc and the stream falls one cc short
      load_settings(8'h00, 3'd0, 5'd31, 64'hBBBB_BBAA_AAAA_AAAA, 64'hCCCC_CCCC_CCCC_BBBB);
      send_plain(8'd5, 8'hAA);
      send_plain(8'd5, 8'hBB);
      send_plain(8'd5, 8'hCC);
      send_plain(8'd1, 8'hDD);
      send_plain(8'd0, 8'hCC);

      // random phases before any match: spoiled patterns and noise, lengths
      // of four and up so a hit by chance stays rare
      for (int unsigned p = 0; p < RAND_PHASES; p++) begin
         make_hint(lo, hi);
         load_settings(8'($urandom), 3'($urandom), 5'($urandom_range(4, 31)), lo, hi);
         if (p == 3) hold_pending = 1'b1;
         phase_end = sent_runs + PHASE_RUNS;
         while (sent_runs < phase_end) begin
            if ($urandom_range(0, 9) < 7)
               send_pattern(1'b1, $urandom_range(0, 3), $urandom_range(0, 3));
            else
               send_noise();
         end
      end

      // first match: near misses and noise, then the real pattern, with extra
      // copies after it so the hit can fall inside a run
      make_hint(lo, hi);
      case ($urandom_range(0, 4))
         0:       len = 5'd0;
         1:       len = 5'd1;
         2:       len = 5'(WINDOW_MAX);
         3:       len = 5'($urandom_range(WINDOW_MAX + 1, 31));
         default: len = 5'($urandom_range(2, WINDOW_MAX - 1));
      endcase
      load_settings(8'($urandom), 3'($urandom), len, lo, hi);
      tries = 0;
      while (!sb.found && tries < 20) begin
         if ($urandom_range(0, 1) == 0) send_pattern(1'b1, $urandom_range(0, 3), 0);
         if ($urandom_range(0, 1) == 0) send_noise();
         send_pattern(1'b0, $urandom_range(0, 3), $urandom_range(0, 6));
         tries++;
      end

      // after the match: exact patterns again must not be reported
      make_hint(lo, hi);
      load_settings(8'($urandom), 3'($urandom), 5'($urandom_range(1, WINDOW_MAX)), lo, hi);
      phase_end = sent_runs + 60;
      while (sent_runs < phase_end) begin
         if ($urandom_range(0, 1) == 0)
            send_pattern(1'b0, $urandom_range(0, 3), $urandom_range(0, 3));
         else
            send_noise();
      end

      // drain, then give a stray result time to show up
      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.expected_runs.size() != 0)
         sb.report($sformatf("%0d results never came back", sb.expected_runs.size()));

      $display("runs sent %0d, results checked %0d, register writes %0d, long holds %0d",
               sent_runs, sb.runs_out, sb.reg_writes, long_holds);
      $display("hint search: %s, start offset %0d, %0d symbols expanded",
               sb.found ? "matched" : "no match", sb.hit_start, sb.stream_pos);
      if (sb.mismatches == 0) begin
         $display("xor_rotate_rle_match_top regression: pass");
      end else begin
         $display("xor_rotate_rle_match_top regression: fail");
      end
      $finish;
   end

endmodule
